>>> hdl/sgna_pkg.sv
// shared types and constants for the softened gravity node accumulator
package sgna_pkg;

    // fixed point format
    localparam int FRAC_BITS = 16;

    // field widths
    localparam int POS_W   = 32;
    localparam int MAG_W   = POS_W + 1;
    localparam int CFG_W   = 32;
    localparam int THETA_W = 16;
    localparam int SUM_W   = 48;
    localparam int CIDX_W  = 2;

    // internal widths
    localparam int Q_W    = 2 * MAG_W;
    localparam int W_W    = Q_W + 2;
    localparam int ROOT_W = W_W / 2;
    localparam int RREM_W = ROOT_W + 2;
    localparam int DEN_W  = W_W + ROOT_W;
    localparam int GM_W   = 2 * CFG_W;
    localparam int NUM_W  = GM_W + MAG_W + FRAC_BITS;
    localparam int T2_W   = 2 * THETA_W;
    localparam int RHS_W  = Q_W + T2_W;
    localparam int LHS_W  = 2 * CFG_W + 32;
    localparam int PROD_W = DEN_W;
    localparam int MPL_W  = ROOT_W;
    localparam int CNT_W  = 8;

    // iteration counts
    localparam logic [CNT_W-1:0] N_SQ    = CNT_W'(MAG_W);
    localparam logic [CNT_W-1:0] N_THETA = CNT_W'(THETA_W);
    localparam logic [CNT_W-1:0] N_QT    = CNT_W'(T2_W);
    localparam logic [CNT_W-1:0] N_SIDE  = CNT_W'(CFG_W);
    localparam logic [CNT_W-1:0] N_SQRT  = CNT_W'(ROOT_W);
    localparam logic [CNT_W-1:0] N_DEN   = CNT_W'(ROOT_W);
    localparam logic [CNT_W-1:0] N_GM    = CNT_W'(CFG_W);
    localparam logic [CNT_W-1:0] N_NUM   = CNT_W'(MAG_W);
    localparam logic [CNT_W-1:0] N_DIV   = CNT_W'(NUM_W);

    // register indexes
    localparam logic [CIDX_W-1:0] CFG_GRAVITY = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_SOFT    = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_THETA   = 2'd2;

    // reset values
    localparam logic [CFG_W-1:0]   GRAVITY_RST = CFG_W'(1) << FRAC_BITS;
    localparam logic [CFG_W-1:0]   SOFT_RST    = CFG_W'(1) << (FRAC_BITS - 4);
    localparam logic [THETA_W-1:0] THETA_RST   = 16'h8000;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_MLOAD,
        OP_MSTEP,
        OP_SAVE,
        OP_WINIT,
        OP_SQSTEP,
        OP_DIVLOAD,
        OP_DIVSTEP,
        OP_ACCUM,
        OP_FINISH
    } dp_op_t;

    typedef enum logic [3:0] {
        MS_AX, MS_AY, MS_AZ, MS_THETA, MS_QT, MS_SIDE, MS_DEN, MS_GM, MS_NUM
    } mul_sel_t;

    typedef enum logic [2:0] {
        SD_Q, SD_T2, SD_RHS, SD_DEN, SD_GM
    } save_dst_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SQX, ST_SQY, ST_SQZ, ST_MRUN, ST_SAVQ, ST_TH, ST_SAVT,
        ST_QT, ST_SAVR, ST_SS, ST_SEP, ST_W, ST_SQRT, ST_DEN, ST_SAVD,
        ST_GM, ST_SAVG, ST_NUM, ST_DIVL, ST_DIV, ST_ACC, ST_FIN
    } ctl_state_t;

    typedef struct packed {
        dp_op_t    op;
        mul_sel_t  msel;
        logic      clr;
        save_dst_t dst;
        logic [1:0] axis;
        logic      open_node;
        logic      applied;
    } dp_cmd_t;

    typedef struct packed {
        logic leaf;
        logic mass_zero;
        logic sep_ok;
        logic den_zero;
    } dp_stat_t;

endpackage

>>> hdl/sgna_ctrl.sv
// sequencer for one particle-node interaction
module sgna_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  sgna_pkg::dp_stat_t stat,
    output sgna_pkg::dp_cmd_t  cmd,
    output logic               capture
);

    sgna_pkg::ctl_state_t state_reg, state_next, ret_reg, ret_next;
    logic [sgna_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0] axis_reg, axis_next;
    logic open_reg, open_next, apply_reg, apply_next;
    logic mvalid_reg, mvalid_next;
    logic out_free;

    assign s_tready = (state_reg == sgna_pkg::ST_IDLE);
    assign capture  = s_tvalid && s_tready;
    assign m_tvalid = mvalid_reg;
    assign out_free = !mvalid_reg || m_tready;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= sgna_pkg::ST_IDLE;
            ret_reg    <= sgna_pkg::ST_IDLE;
            cnt_reg    <= '0;
            axis_reg   <= '0;
            open_reg   <= 1'b0;
            apply_reg  <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            cnt_reg    <= cnt_next;
            axis_reg   <= axis_next;
            open_reg   <= open_next;
            apply_reg  <= apply_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // next state
    always_comb begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        cnt_next    = cnt_reg;
        axis_next   = axis_reg;
        open_next   = open_reg;
        apply_next  = apply_reg;
        mvalid_next = mvalid_reg && !m_tready;
        unique case (state_reg)
            sgna_pkg::ST_IDLE: begin
                if (capture) begin
                    state_next = sgna_pkg::ST_SQX;
                    open_next  = 1'b0;
                    apply_next = 1'b0;
                end
            end
            sgna_pkg::ST_SQX: begin
                cnt_next = sgna_pkg::N_SQ; ret_next = sgna_pkg::ST_SQY;
                state_next = sgna_pkg::ST_MRUN;
            end
            sgna_pkg::ST_SQY: begin
                cnt_next = sgna_pkg::N_SQ; ret_next = sgna_pkg::ST_SQZ;
                state_next = sgna_pkg::ST_MRUN;
            end
            sgna_pkg::ST_SQZ: begin
                cnt_next = sgna_pkg::N_SQ; ret_next = sgna_pkg::ST_SAVQ;
                state_next = sgna_pkg::ST_MRUN;
            end
            sgna_pkg::ST_MRUN: begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == sgna_pkg::CNT_W'(1)) state_next = ret_reg;
            end
            sgna_pkg::ST_SAVQ: begin
                priority if (!stat.leaf) begin
                    state_next = sgna_pkg::ST_TH;
                end else if (stat.mass_zero) begin
                    state_next = sgna_pkg::ST_FIN;
                end else begin
                    apply_next = 1'b1;
                    state_next = sgna_pkg::ST_W;
                end
            end
            sgna_pkg::ST_TH: begin
                cnt_next = sgna_pkg::N_THETA; ret_next = sgna_pkg::ST_SAVT;
                state_next = sgna_pkg::ST_MRUN;
            end
            sgna_pkg::ST_SAVT: state_next = sgna_pkg::ST_QT;
            sgna_pkg::ST_QT: begin
                cnt_next = sgna_pkg::N_QT; ret_next = sgna_pkg::ST_SAVR;
                state_next = sgna_pkg::ST_MRUN;
            end
            sgna_pkg::ST_SAVR: state_next = sgna_pkg::ST_SS;
            sgna_pkg::ST_SS: begin
                cnt_next = sgna_pkg::N_SIDE; ret_next = sgna_pkg::ST_SEP;
                state_next = sgna_pkg::ST_MRUN;
            end
            sgna_pkg::ST_SEP: begin
                if (stat.sep_ok) begin
                    apply_next = 1'b1;
                    state_next = sgna_pkg::ST_W;
                end else begin
                    open_next  = 1'b1;
                    state_next = sgna_pkg::ST_FIN;
                end
            end
            sgna_pkg::ST_W: begin
                cnt_next = sgna_pkg::N_SQRT;
                state_next = sgna_pkg::ST_SQRT;
            end
            sgna_pkg::ST_SQRT: begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == sgna_pkg::CNT_W'(1)) state_next = sgna_pkg::ST_DEN;
            end
            sgna_pkg::ST_DEN: begin
                cnt_next = sgna_pkg::N_DEN; ret_next = sgna_pkg::ST_SAVD;
                state_next = sgna_pkg::ST_MRUN;
            end
            sgna_pkg::ST_SAVD: begin
                state_next = stat.den_zero ? sgna_pkg::ST_FIN : sgna_pkg::ST_GM;
            end
            sgna_pkg::ST_GM: begin
                cnt_next = sgna_pkg::N_GM; ret_next = sgna_pkg::ST_SAVG;
                state_next = sgna_pkg::ST_MRUN;
            end
            sgna_pkg::ST_SAVG: begin
                axis_next  = '0;
                state_next = sgna_pkg::ST_NUM;
            end
            sgna_pkg::ST_NUM: begin
                cnt_next = sgna_pkg::N_NUM; ret_next = sgna_pkg::ST_DIVL;
                state_next = sgna_pkg::ST_MRUN;
            end
            sgna_pkg::ST_DIVL: begin
                cnt_next = sgna_pkg::N_DIV;
                state_next = sgna_pkg::ST_DIV;
            end
            sgna_pkg::ST_DIV: begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == sgna_pkg::CNT_W'(1)) state_next = sgna_pkg::ST_ACC;
            end
            sgna_pkg::ST_ACC: begin
                axis_next = axis_reg + 1'b1;
                state_next = (axis_reg == 2'd2) ? sgna_pkg::ST_FIN : sgna_pkg::ST_NUM;
            end
            sgna_pkg::ST_FIN: begin
                if (out_free) begin
                    mvalid_next = 1'b1;
                    state_next  = sgna_pkg::ST_IDLE;
                end
            end
            default: state_next = sgna_pkg::ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        cmd.op        = sgna_pkg::OP_NONE;
        cmd.msel      = sgna_pkg::MS_AX;
        cmd.clr       = 1'b1;
        cmd.dst       = sgna_pkg::SD_Q;
        cmd.axis      = axis_reg;
        cmd.open_node = open_reg;
        cmd.applied   = apply_reg;
        unique case (state_reg)
            sgna_pkg::ST_SQX: begin cmd.op = sgna_pkg::OP_MLOAD; cmd.msel = sgna_pkg::MS_AX; end
            sgna_pkg::ST_SQY: begin
                cmd.op = sgna_pkg::OP_MLOAD; cmd.msel = sgna_pkg::MS_AY; cmd.clr = 1'b0;
            end
            sgna_pkg::ST_SQZ: begin
                cmd.op = sgna_pkg::OP_MLOAD; cmd.msel = sgna_pkg::MS_AZ; cmd.clr = 1'b0;
            end
            sgna_pkg::ST_MRUN: cmd.op = sgna_pkg::OP_MSTEP;
            sgna_pkg::ST_SAVQ: begin cmd.op = sgna_pkg::OP_SAVE; cmd.dst = sgna_pkg::SD_Q; end
            sgna_pkg::ST_TH: begin cmd.op = sgna_pkg::OP_MLOAD; cmd.msel = sgna_pkg::MS_THETA; end
            sgna_pkg::ST_SAVT: begin cmd.op = sgna_pkg::OP_SAVE; cmd.dst = sgna_pkg::SD_T2; end
            sgna_pkg::ST_QT: begin cmd.op = sgna_pkg::OP_MLOAD; cmd.msel = sgna_pkg::MS_QT; end
            sgna_pkg::ST_SAVR: begin cmd.op = sgna_pkg::OP_SAVE; cmd.dst = sgna_pkg::SD_RHS; end
            sgna_pkg::ST_SS: begin cmd.op = sgna_pkg::OP_MLOAD; cmd.msel = sgna_pkg::MS_SIDE; end
            sgna_pkg::ST_W: cmd.op = sgna_pkg::OP_WINIT;
            sgna_pkg::ST_SQRT: cmd.op = sgna_pkg::OP_SQSTEP;
            sgna_pkg::ST_DEN: begin cmd.op = sgna_pkg::OP_MLOAD; cmd.msel = sgna_pkg::MS_DEN; end
            sgna_pkg::ST_SAVD: begin cmd.op = sgna_pkg::OP_SAVE; cmd.dst = sgna_pkg::SD_DEN; end
            sgna_pkg::ST_GM: begin cmd.op = sgna_pkg::OP_MLOAD; cmd.msel = sgna_pkg::MS_GM; end
            sgna_pkg::ST_SAVG: begin cmd.op = sgna_pkg::OP_SAVE; cmd.dst = sgna_pkg::SD_GM; end
            sgna_pkg::ST_NUM: begin cmd.op = sgna_pkg::OP_MLOAD; cmd.msel = sgna_pkg::MS_NUM; end
            sgna_pkg::ST_DIVL: cmd.op = sgna_pkg::OP_DIVLOAD;
            sgna_pkg::ST_DIV: cmd.op = sgna_pkg::OP_DIVSTEP;
            sgna_pkg::ST_ACC: cmd.op = sgna_pkg::OP_ACCUM;
            sgna_pkg::ST_FIN: if (out_free) cmd.op = sgna_pkg::OP_FINISH;
            default: cmd.op = sgna_pkg::OP_NONE;
        endcase
    end

endmodule

>>> hdl/sgna_datapath.sv
// shift-add multiplier, square root, divider and saturating sums
module sgna_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [sgna_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [sgna_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          capture,
    input  logic [319:0]                  s_tdata,
    input  logic                          s_tuser,
    input  logic                          s_tlast,
    input  sgna_pkg::dp_cmd_t             cmd,
    output sgna_pkg::dp_stat_t            stat,
    output logic [143:0]                  m_tdata,
    output logic [1:0]                    m_tuser,
    output logic                          m_tlast
);

    localparam int PW = sgna_pkg::POS_W;
    localparam int MW = sgna_pkg::MAG_W;
    localparam int SW = sgna_pkg::SUM_W;

    // configuration
    logic [sgna_pkg::CFG_W-1:0]   grav_reg, soft_reg;
    logic [sgna_pkg::THETA_W-1:0] theta_reg;

    // captured word
    logic [MW-1:0] abs_reg [3];
    logic [2:0]    neg_reg;
    logic [PW-1:0] mass_reg, side_reg;
    logic          leaf_reg, last_reg;

    // arithmetic state
    logic [sgna_pkg::PROD_W-1:0] acc_reg, mcand_reg;
    logic [sgna_pkg::MPL_W-1:0]  mplier_reg;
    logic [sgna_pkg::Q_W-1:0]    q_reg;
    logic [sgna_pkg::T2_W-1:0]   t2_reg;
    logic [sgna_pkg::RHS_W-1:0]  rhs_reg;
    logic [sgna_pkg::W_W-1:0]    w_reg, wsh_reg;
    logic [sgna_pkg::ROOT_W-1:0] root_reg;
    logic [sgna_pkg::RREM_W-1:0] srem_reg;
    logic [sgna_pkg::DEN_W-1:0]  den_reg, drem_reg;
    logic [sgna_pkg::GM_W-1:0]   gm_reg;
    logic [sgna_pkg::NUM_W-1:0]  dnum_reg, quo_reg;
    logic [SW-1:0]               sum_reg [3];

    // output register
    logic [SW-1:0] out_sum_reg [3];
    logic          out_open_reg, out_apply_reg, out_last_reg;

    // capture arithmetic
    logic signed [MW-1:0] rel [3];
    logic [PW-1:0] sx, sy, sz, smax;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rel[i] = $signed({s_tdata[(i+3)*PW + PW-1], s_tdata[(i+3)*PW +: PW]})
                   - $signed({s_tdata[i*PW + PW-1], s_tdata[i*PW +: PW]});
        end
        sx = s_tdata[7*PW +: PW];
        sy = s_tdata[8*PW +: PW];
        sz = s_tdata[9*PW +: PW];
        smax = sx;
        if (sy > smax) smax = sy;
        if (sz > smax) smax = sz;
    end

    // multiplier operand select
    logic [sgna_pkg::PROD_W-1:0] op_a;
    logic [sgna_pkg::MPL_W-1:0]  op_b;
    always_comb begin
        unique case (cmd.msel)
            sgna_pkg::MS_AX: begin
                op_a = sgna_pkg::PROD_W'(abs_reg[0]); op_b = sgna_pkg::MPL_W'(abs_reg[0]);
            end
            sgna_pkg::MS_AY: begin
                op_a = sgna_pkg::PROD_W'(abs_reg[1]); op_b = sgna_pkg::MPL_W'(abs_reg[1]);
            end
            sgna_pkg::MS_AZ: begin
                op_a = sgna_pkg::PROD_W'(abs_reg[2]); op_b = sgna_pkg::MPL_W'(abs_reg[2]);
            end
            sgna_pkg::MS_THETA: begin
                op_a = sgna_pkg::PROD_W'(theta_reg); op_b = sgna_pkg::MPL_W'(theta_reg);
            end
            sgna_pkg::MS_QT: begin
                op_a = sgna_pkg::PROD_W'(q_reg); op_b = sgna_pkg::MPL_W'(t2_reg);
            end
            sgna_pkg::MS_SIDE: begin
                op_a = sgna_pkg::PROD_W'(side_reg); op_b = sgna_pkg::MPL_W'(side_reg);
            end
            sgna_pkg::MS_DEN: begin
                op_a = sgna_pkg::PROD_W'(w_reg); op_b = root_reg;
            end
            sgna_pkg::MS_GM: begin
                op_a = sgna_pkg::PROD_W'(grav_reg); op_b = sgna_pkg::MPL_W'(mass_reg);
            end
            sgna_pkg::MS_NUM: begin
                op_a = sgna_pkg::PROD_W'(gm_reg); op_b = sgna_pkg::MPL_W'(abs_reg[cmd.axis]);
            end
            default: begin
                op_a = '0; op_b = '0;
            end
        endcase
    end

    // square root step
    logic [sgna_pkg::RREM_W+1:0] srem_sh, strial;
    logic                        sq_ge;
    always_comb begin
        srem_sh = {srem_reg, wsh_reg[sgna_pkg::W_W-1 -: 2]};
        strial  = (sgna_pkg::RREM_W+2)'({root_reg, 2'b01});
        sq_ge   = srem_sh >= strial;
    end

    // divider step
    logic [sgna_pkg::DEN_W:0] drem_sh, ddiff;
    logic                     div_ge;
    always_comb begin
        drem_sh = {drem_reg, dnum_reg[sgna_pkg::NUM_W-1]};
        ddiff   = drem_sh - {1'b0, den_reg};
        div_ge  = drem_sh >= {1'b0, den_reg};
    end

    // term saturation and saturating add
    logic [SW-2:0]        tmag;
    logic signed [SW:0]   term, ssum;
    logic [SW-1:0]        sat_sum;
    always_comb begin
        tmag = (|quo_reg[sgna_pkg::NUM_W-1:SW-1]) ? '1 : quo_reg[SW-2:0];
        term = neg_reg[cmd.axis] ? -$signed({2'b00, tmag}) : $signed({2'b00, tmag});
        ssum = $signed({sum_reg[cmd.axis][SW-1], sum_reg[cmd.axis]}) + term;
        priority if (ssum[SW] != ssum[SW-1]) begin
            sat_sum = ssum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end else begin
            sat_sum = ssum[SW-1:0];
        end
    end

    // separation test and status
    logic [sgna_pkg::RHS_W-1:0] lhs;
    always_comb begin
        lhs = sgna_pkg::RHS_W'({acc_reg[2*PW-1:0], 32'd0});
        stat.leaf      = leaf_reg;
        stat.mass_zero = (mass_reg == '0);
        stat.sep_ok    = lhs < rhs_reg;
        stat.den_zero  = (acc_reg == '0);
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grav_reg  <= sgna_pkg::GRAVITY_RST;
            soft_reg  <= sgna_pkg::SOFT_RST;
            theta_reg <= sgna_pkg::THETA_RST;
        end else if (cfg_we) begin
            priority case (cfg_index)
                sgna_pkg::CFG_GRAVITY: grav_reg  <= cfg_wdata;
                sgna_pkg::CFG_SOFT:    soft_reg  <= cfg_wdata;
                sgna_pkg::CFG_THETA:   theta_reg <= cfg_wdata[sgna_pkg::THETA_W-1:0];
                default: ;
            endcase
        end
    end

    // running sums
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) sum_reg[i] <= '0;
        end else if (cmd.op == sgna_pkg::OP_ACCUM) begin
            sum_reg[cmd.axis] <= sat_sum;
        end else if (cmd.op == sgna_pkg::OP_FINISH && last_reg) begin
            for (int i = 0; i < 3; i++) sum_reg[i] <= '0;
        end
    end

    // input capture
    always_ff @(posedge aclk) begin
        if (capture) begin
            for (int i = 0; i < 3; i++) begin
                neg_reg[i] <= rel[i][MW-1];
                abs_reg[i] <= rel[i][MW-1] ? MW'(-rel[i]) : MW'(rel[i]);
            end
            mass_reg <= s_tdata[6*PW +: PW];
            side_reg <= smax;
            leaf_reg <= s_tuser;
            last_reg <= s_tlast;
        end
    end

    // arithmetic units
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            sgna_pkg::OP_MLOAD: begin
                mcand_reg  <= op_a;
                mplier_reg <= op_b;
                if (cmd.clr) acc_reg <= '0;
            end
            sgna_pkg::OP_MSTEP: begin
                if (mplier_reg[0]) acc_reg <= acc_reg + mcand_reg;
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
            end
            sgna_pkg::OP_SAVE: begin
                unique case (cmd.dst)
                    sgna_pkg::SD_Q:   q_reg   <= acc_reg[sgna_pkg::Q_W-1:0];
                    sgna_pkg::SD_T2:  t2_reg  <= acc_reg[sgna_pkg::T2_W-1:0];
                    sgna_pkg::SD_RHS: rhs_reg <= acc_reg[sgna_pkg::RHS_W-1:0];
                    sgna_pkg::SD_DEN: den_reg <= acc_reg[sgna_pkg::DEN_W-1:0];
                    sgna_pkg::SD_GM:  gm_reg  <= acc_reg[sgna_pkg::GM_W-1:0];
                    default: ;
                endcase
            end
            sgna_pkg::OP_WINIT: begin
                w_reg    <= sgna_pkg::W_W'(q_reg)
                          + (sgna_pkg::W_W'(soft_reg) << sgna_pkg::FRAC_BITS);
                wsh_reg  <= sgna_pkg::W_W'(q_reg)
                          + (sgna_pkg::W_W'(soft_reg) << sgna_pkg::FRAC_BITS);
                root_reg <= '0;
                srem_reg <= '0;
            end
            sgna_pkg::OP_SQSTEP: begin
                wsh_reg  <= wsh_reg << 2;
                root_reg <= {root_reg[sgna_pkg::ROOT_W-2:0], sq_ge};
                srem_reg <= sq_ge ? sgna_pkg::RREM_W'(srem_sh - strial)
                                  : srem_sh[sgna_pkg::RREM_W-1:0];
            end
            sgna_pkg::OP_DIVLOAD: begin
                dnum_reg <= {acc_reg[sgna_pkg::GM_W+MW-1:0], {sgna_pkg::FRAC_BITS{1'b0}}};
                drem_reg <= '0;
                quo_reg  <= '0;
            end
            sgna_pkg::OP_DIVSTEP: begin
                dnum_reg <= dnum_reg << 1;
                drem_reg <= div_ge ? ddiff[sgna_pkg::DEN_W-1:0] : drem_sh[sgna_pkg::DEN_W-1:0];
                quo_reg  <= {quo_reg[sgna_pkg::NUM_W-2:0], div_ge};
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.op == sgna_pkg::OP_FINISH) begin
            for (int i = 0; i < 3; i++) out_sum_reg[i] <= sum_reg[i];
            out_open_reg  <= cmd.open_node;
            out_apply_reg <= cmd.applied;
            out_last_reg  <= last_reg;
        end
    end

    assign m_tdata = {out_sum_reg[2], out_sum_reg[1], out_sum_reg[0]};
    assign m_tuser = {out_apply_reg, out_open_reg};
    assign m_tlast = out_last_reg;

endmodule

>>> hdl/softened_gravity_node_accumulator.sv
// top level of the softened gravity node accumulator
//
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  tdata positions, mass, sides; tuser is_leaf; tlast last
// m_       out  m_tvalid/m_tready  tdata accel x,y,z; tuser open_node, applied; tlast done_res
// cfg_     in   cfg_we             cfg_index, cfg_wdata
//
// one word at a time through a shared shift-add multiplier, a two-bit-per-step
// square root and a restoring divider; an applied node with a nonzero denominator
// runs three divisions, one per axis, and a skipped leaf or an opened node none.
// synchronous active-low reset clears the sequencer, the sums and the config registers.
// the next word is taken while a result waits in the output register.
module softened_gravity_node_accumulator (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [sgna_pkg::CIDX_W-1:0] cfg_index,
    input  logic [sgna_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // part_x, part_y, part_z, centre_x, centre_y, centre_z, node_mass,
    // side_x, side_y, side_z
    input  logic [319:0]                s_tdata,
    // is_leaf
    input  logic                        s_tuser,
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // accel_x, accel_y, accel_z
    output logic [143:0]                m_tdata,
    // open_node, applied
    output logic [1:0]                  m_tuser,
    output logic                        m_tlast
);

    sgna_pkg::dp_cmd_t  cmd;
    sgna_pkg::dp_stat_t stat;
    logic               capture;

    // sequencer
    sgna_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd),
        .capture  (capture)
    );

    // arithmetic
    sgna_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .capture   (capture),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cmd       (cmd),
        .stat      (stat),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

>>> verif/softened_gravity_node_accumulator_checker.sv
// result checker for the softened gravity node accumulator: predicts each result word and compares
module softened_gravity_node_accumulator_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [sgna_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [sgna_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [319:0]                  s_tdata,
    input  logic                          s_tuser,
    input  logic                          s_tlast,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [143:0]                  m_tdata,
    input  logic [1:0]                    m_tuser,
    input  logic                          m_tlast,
    output int                            mismatch_count,
    output int                            words_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic signed [49:0] ACC_MAX = 50'sd140737488355327;
    localparam logic signed [49:0] ACC_MIN = -50'sd140737488355328;

    typedef struct {
        logic        open_node;
        logic        applied;
        logic [47:0] accel_x;
        logic [47:0] accel_y;
        logic [47:0] accel_z;
        logic        done_res;
    } accel_word_t;

    accel_word_t expected_accel_q[$];

    // model copy of registers and running sums
    logic [sgna_pkg::CFG_W-1:0]   grav_reg;
    logic [sgna_pkg::CFG_W-1:0]   soft_reg;
    logic [sgna_pkg::THETA_W-1:0] theta_reg;
    logic signed [49:0] acc_x, acc_y, acc_z;

    function automatic logic [127:0] floor_root(logic [127:0] v);
        logic [127:0] r;
        logic [127:0] t;
        r = '0;
        for (int b = 35; b >= 0; b--) begin
            t = r | (128'd1 << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    // add one axis of the force term to a running sum, both saturated
    function automatic logic signed [49:0] add_axis_term(logic signed [49:0] acc,
            logic signed [33:0] rel, logic [127:0] gm, logic [127:0] den);
        logic [33:0]        rel_mag;
        logic [127:0]       quo;
        logic [46:0]        mag;
        logic signed [49:0] d;
        logic signed [49:0] s;
        rel_mag = rel[33] ? -rel : rel;
        quo = ((gm * {94'd0, rel_mag}) << sgna_pkg::FRAC_BITS) / den;
        mag = (quo > 128'h7FFF_FFFF_FFFF) ? 47'h7FFF_FFFF_FFFF : quo[46:0];
        d = {3'b000, mag};
        s = rel[33] ? acc - d : acc + d;
        if (s > ACC_MAX) s = ACC_MAX;
        if (s < ACC_MIN) s = ACC_MIN;
        return s;
    endfunction

    // one node interaction: updates the sums and returns the word to expect
    function automatic accel_word_t predict_interaction(logic [319:0] data, logic leaf,
            logic last);
        logic signed [33:0] rx, ry, rz;
        logic [33:0]        mx, my, mz;
        logic [31:0]        mass, side;
        logic [127:0]       qd, lhs, rhs, w, den, gm;
        logic               apply, open;
        accel_word_t        res;
        rx = $signed({{2{data[127]}}, data[127:96]}) - $signed({{2{data[31]}}, data[31:0]});
        ry = $signed({{2{data[159]}}, data[159:128]}) - $signed({{2{data[63]}}, data[63:32]});
        rz = $signed({{2{data[191]}}, data[191:160]}) - $signed({{2{data[95]}}, data[95:64]});
        mx = rx[33] ? -rx : rx;
        my = ry[33] ? -ry : ry;
        mz = rz[33] ? -rz : rz;
        mass = data[223:192];
        side = data[255:224];
        if (data[287:256] > side) side = data[287:256];
        if (data[319:288] > side) side = data[319:288];
        qd = 128'(mx) * 128'(mx) + 128'(my) * 128'(my) + 128'(mz) * 128'(mz);
        open = 1'b0;
        if (leaf) begin
            apply = (mass != 0);
        end else begin
            lhs = (128'(side) * 128'(side)) << 32;
            rhs = qd * (128'(theta_reg) * 128'(theta_reg));
            apply = lhs < rhs;
            open = !apply;
        end
        if (apply) begin
            w = qd + (128'(soft_reg) << sgna_pkg::FRAC_BITS);
            den = w * floor_root(w);
            if (den != 0) begin
                gm = 128'(grav_reg) * 128'(mass);
                acc_x = add_axis_term(acc_x, rx, gm, den);
                acc_y = add_axis_term(acc_y, ry, gm, den);
                acc_z = add_axis_term(acc_z, rz, gm, den);
            end
        end
        res.open_node = open;
        res.applied   = apply;
        res.accel_x   = acc_x[47:0];
        res.accel_y   = acc_y[47:0];
        res.accel_z   = acc_z[47:0];
        res.done_res  = last;
        if (last) begin
            acc_x = '0;
            acc_y = '0;
            acc_z = '0;
        end
        return res;
    endfunction

    assign words_outstanding = expected_accel_q.size();

    // register mirror, prediction on accepted input words
    always @(posedge aclk) begin
        if (!aresetn) begin
            grav_reg  <= sgna_pkg::GRAVITY_RST;
            soft_reg  <= sgna_pkg::SOFT_RST;
            theta_reg <= sgna_pkg::THETA_RST;
            acc_x = '0;
            acc_y = '0;
            acc_z = '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    sgna_pkg::CFG_GRAVITY: grav_reg <= cfg_wdata;
                    sgna_pkg::CFG_SOFT:    soft_reg <= cfg_wdata;
                    sgna_pkg::CFG_THETA:   theta_reg <= cfg_wdata[sgna_pkg::THETA_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_accel_q.push_back(predict_interaction(s_tdata, s_tuser, s_tlast));
        end
    end

    // compare accepted result words with the oldest prediction
    always @(posedge aclk) begin
        accel_word_t exp_w;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_accel_q.size() == 0) begin
                $error("result word with no prediction pending");
                mismatch_count++;
            end else begin
                exp_w = expected_accel_q.pop_front();
                if (m_tuser[0] !== exp_w.open_node) begin
                    $error("open_node: expected %0b actual %0b", exp_w.open_node, m_tuser[0]);
                    mismatch_count++;
                end
                if (m_tuser[1] !== exp_w.applied) begin
                    $error("applied: expected %0b actual %0b", exp_w.applied, m_tuser[1]);
                    mismatch_count++;
                end
                if (m_tdata[47:0] !== exp_w.accel_x) begin
                    $error("accel_x: expected %h actual %h", exp_w.accel_x, m_tdata[47:0]);
                    mismatch_count++;
                end
                if (m_tdata[95:48] !== exp_w.accel_y) begin
                    $error("accel_y: expected %h actual %h", exp_w.accel_y, m_tdata[95:48]);
                    mismatch_count++;
                end
                if (m_tdata[143:96] !== exp_w.accel_z) begin
                    $error("accel_z: expected %h actual %h", exp_w.accel_z, m_tdata[143:96]);
                    mismatch_count++;
                end
                if (m_tlast !== exp_w.done_res) begin
                    $error("done_res: expected %0b actual %0b", exp_w.done_res, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

endmodule

>>> verif/softened_gravity_node_accumulator_test.sv
// testbench top for the softened gravity node accumulator: stimulus, stalls and verdict
module softened_gravity_node_accumulator_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [sgna_pkg::CIDX_W-1:0]   cfg_index = sgna_pkg::CFG_GRAVITY;
    logic [sgna_pkg::CFG_W-1:0]    cfg_wdata = '0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    // part_x, part_y, part_z, centre_x, centre_y, centre_z, node_mass, side_x, side_y, side_z
    logic [319:0]                  s_tdata = '0;
    // is_leaf
    logic                          s_tuser = 1'b0;
    logic                          s_tlast = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    // accel_x, accel_y, accel_z
    logic [143:0]                  m_tdata;
    // open_node, applied
    logic [1:0]                    m_tuser;
    logic                          m_tlast;
    int                            mismatch_count;
    int                            words_outstanding;
    int                            burst_left = 0;
    int                            stall_cycle = 0;

    always #6 aclk = ~aclk;

    softened_gravity_node_accumulator DUT (.*);

    softened_gravity_node_accumulator_checker u_checker (.*);

    // receiver stalls: always ready, random, then mostly stalled, in turn
    always @(posedge aclk) begin
        stall_cycle <= stall_cycle + 1;
        case ((stall_cycle / 3000) % 3)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // send one word, with random gaps between bursts
    task automatic send_node(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
            logic [31:0] cx, logic [31:0] cy, logic [31:0] cz, logic [31:0] mass,
            logic [31:0] sx, logic [31:0] sy, logic [31:0] sz, logic leaf, logic last);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 400)) @(posedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {sz, sy, sx, mass, cz, cy, cx, pz, py, px};
        s_tuser  <= leaf;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (words_outstanding != 0) @(posedge aclk);
        repeat (800) @(posedge aclk);
    endtask

    task automatic set_regs(logic [31:0] g, logic [31:0] soft_val, logic [15:0] theta);
        cfg_we <= 1'b1;
        cfg_index <= sgna_pkg::CFG_GRAVITY;
        cfg_wdata <= g;
        @(posedge aclk);
        cfg_index <= sgna_pkg::CFG_SOFT;
        cfg_wdata <= soft_val;
        @(posedge aclk);
        cfg_index <= sgna_pkg::CFG_THETA;
        cfg_wdata <= {16'd0, theta};
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] scaled_rand();
        return $urandom >> $urandom_range(0, 31);
    endfunction

    function automatic logic [31:0] scaled_signed();
        logic [31:0] v;
        v = scaled_rand();
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    // groups of nodes for one particle; mostly nearby nodes, some raw noise
    task automatic random_groups(int count);
        logic [31:0] px, py, pz, mass;
        int          left;
        left = 0;
        for (int i = 0; i < count; i++) begin
            if (left == 0) begin
                left = $urandom_range(1, 8);
                px = scaled_signed();
                py = scaled_signed();
                pz = scaled_signed();
            end
            left--;
            mass = ($urandom_range(0, 9) == 0) ? 32'd0 : scaled_rand();
            if ($urandom_range(0, 9) == 0)
                send_node($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            else if ($urandom_range(0, 19) == 0)
                send_node(px, py, pz, px, py, pz, mass, scaled_rand(), scaled_rand(),
                          scaled_rand(), 1'($urandom_range(0, 1)), left == 0);
            else
                send_node(px, py, pz, px + scaled_signed(), py + scaled_signed(),
                          pz + scaled_signed(), mass, scaled_rand(), scaled_rand(),
                          scaled_rand(), 1'($urandom_range(0, 1)), left == 0);
            if (i == count / 2 && count > 100) wait_drained();
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed cases at reset settings
        // massless leaf
        send_node(0, 0, 0, 32'h10000, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0);
        // leaf with mass
        send_node(0, 0, 0, 32'h10000, 0, 0, 32'h10000, 0, 0, 0, 1'b1, 1'b0);
        // far internal node
        send_node(0, 0, 0, 32'h0, 32'hFFF00000, 0, 32'h20000, 32'h100, 32'h200, 32'h300,
                  1'b0, 1'b0);
        // too close
        send_node(0, 0, 0, 32'h10000, 0, 0, 32'h10000, 32'h40000, 0, 0, 1'b0, 1'b0);
        // zero distance internal
        send_node(5, 6, 7, 5, 6, 7, 32'h10000, 0, 0, 0, 1'b0, 1'b0);
        // zero distance leaf, last
        send_node(5, 6, 7, 5, 6, 7, 32'h10000, 0, 0, 0, 1'b1, 1'b1);
        // extreme spread
        send_node(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                  32'h7FFFFFFF, 32'hFFFFFFFF, 0, 0, 0, 1'b1, 1'b0);
        // massless internal far
        send_node(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                  32'h80000000, 0, 32'h1, 32'h1, 32'h1, 1'b0, 1'b0);
        // max sides
        send_node(0, 0, 0, 32'h100, 32'h100, 32'h100, 32'h10000, 32'hFFFFFFFF,
                  32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 1'b1);
        wait_drained();

        // strong gravity, no softening, widest angle
        set_regs(32'hFFFFFFFF, 32'h0, 16'hFFFF);
        // zero denominator
        send_node(9, 9, 9, 9, 9, 9, 32'h10000, 0, 0, 0, 1'b1, 1'b0);
        // sums saturate
        for (int k = 0; k < 6; k++)
            send_node(0, 0, 0, 32'h1, 32'hFFFFFFFF, 32'h2, 32'hFFFFFFFF, 0, 0, 0, 1'b1,
                      k == 5);
        send_node(0, 0, 0, 32'h10000, 32'h10000, 0, 32'h8000, 32'h10000, 0, 0, 1'b0, 1'b1);
        random_groups(250);
        wait_drained();

        // no gravity, huge softening, zero angle
        set_regs(32'h0, 32'hFFFFFFFF, 16'h0);
        random_groups(150);
        wait_drained();

        set_regs($urandom, $urandom, 16'($urandom));
        random_groups(250);
        wait_drained();

        set_regs(sgna_pkg::GRAVITY_RST, sgna_pkg::SOFT_RST, sgna_pkg::THETA_RST);
        random_groups(380);
        wait_drained();

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #(150_000_000);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
hdl/sgna_pkg.sv
hdl/sgna_ctrl.sv
hdl/sgna_datapath.sv
hdl/softened_gravity_node_accumulator.sv
verif/softened_gravity_node_accumulator_checker.sv
verif/softened_gravity_node_accumulator_test.sv
